/* design/plob_pkg.sv */
package plob_pkg;

  localparam int LEVELS = 64;
  localparam int PW     = 24;
  localparam int IQW    = 32;
  localparam int QW     = 40;
  localparam logic [QW-1:0] QMAX = {QW{1'b1}};

  localparam logic [1:0] OP_TRADE  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]     opcode;
    logic           is_buy;
    logic [PW-1:0]  price;
    logic [IQW-1:0] quantity;
    logic [5:0]     query_level;
  } in_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [PW-1:0] best_bid;
    logic          bid_present;
    logic [PW-1:0] best_ask;
    logic          ask_present;
    logic [PW-1:0] spread;
    logic [QW-1:0] level_bid_volume;
    logic [QW-1:0] level_ask_volume;
    logic [QW-1:0] volume_at_price;
  } out_t;

  typedef struct packed {
    logic          valid;
    logic [PW-1:0] price;
    logic [QW-1:0] qty;
  } ent_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_ADD    = 2'd2,
    CMD_REDUCE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t           cmd;
    logic           is_ask;
    logic           found;
    logic           remove;
    logic [PW-1:0]  price;
    logic [IQW-1:0] qty;
    logic [5:0]     qlevel;
  } ctrl_t;

  typedef struct packed {
    logic          found;
    logic          full;
    logic [QW-1:0] mqty;
    logic [QW-1:0] qvol;
    ent_t          head;
  } side_stat_t;

endpackage

/* design/plob_cell.sv */
module plob_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  plob_pkg::ctrl_t ctrl,
  input  plob_pkg::ent_t left_ent,
  input  plob_pkg::ent_t right_ent,
  input  logic           ins_prev,
  output logic           ins,
  output logic           match,
  output plob_pkg::ent_t ent
);
  import plob_pkg::*;

  ent_t        ent_r, ent_nxt;
  logic        p_before, c_before_p, aoa;
  logic [QW:0] sum;

  assign p_before   = ctrl.is_ask ? (ctrl.price < ent_r.price) : (ctrl.price > ent_r.price);
  assign c_before_p = ctrl.is_ask ? (ent_r.price < ctrl.price) : (ent_r.price > ctrl.price);
  assign match = ent_r.valid && (ent_r.price == ctrl.price);
  assign ins   = !ent_r.valid || p_before;
  assign aoa   = ent_r.valid && !c_before_p;
  assign sum   = {1'b0, ent_r.qty} + {{(QW+1-IQW){1'b0}}, ctrl.qty};
  assign ent   = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (ctrl.cmd)
      CMD_POP: ent_nxt = right_ent;
      CMD_ADD: begin
        if (ctrl.found) begin
          if (match) ent_nxt.qty = sum[QW] ? QMAX : sum[QW-1:0];
        end else if (ins_prev) begin
          ent_nxt = left_ent;
        end else if (ins) begin
          ent_nxt = '{valid: 1'b1, price: ctrl.price,
                      qty: {{(QW-IQW){1'b0}}, ctrl.qty}};
        end
      end
      CMD_REDUCE: begin
        if (ctrl.remove) begin
          if (aoa) ent_nxt = right_ent;
        end else if (match) begin
          ent_nxt.qty = ent_r.qty - {{(QW-IQW){1'b0}}, ctrl.qty};
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  // valid lives in the entry; reset empties the cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end
endmodule

/* design/plob_side.sv */
module plob_side (
  input  logic                  clk,
  input  logic                  rst_n,
  input  plob_pkg::ctrl_t       ctrl,
  output plob_pkg::side_stat_t  stat
);
  import plob_pkg::*;

  ent_t              ents [LEVELS];
  logic [LEVELS-1:0] ins_v, match_v;
  logic [QW-1:0]     mqty, qvol;

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    ent_t lft, rgt;
    logic ip;
    if (i == 0) begin : g_first
      assign lft = '0;
      assign ip  = 1'b0;
    end else begin : g_mid
      assign lft = ents[i-1];
      assign ip  = ins_v[i-1];
    end
    if (i == LEVELS-1) begin : g_last
      assign rgt = '0;
    end else begin : g_inner
      assign rgt = ents[i+1];
    end
    plob_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .left_ent  (lft),
      .right_ent (rgt),
      .ins_prev  (ip),
      .ins       (ins_v[i]),
      .match     (match_v[i]),
      .ent       (ents[i])
    );
  end

  always_comb begin
    mqty = '0;
    qvol = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (match_v[i]) mqty = mqty | ents[i].qty;
      if (ents[i].valid && (i == int'(ctrl.qlevel))) qvol = qvol | ents[i].qty;
    end
  end

  assign stat.found = |match_v;
  assign stat.full  = ents[LEVELS-1].valid;
  assign stat.mqty  = mqty;
  assign stat.qvol  = qvol;
  assign stat.head  = ents[0];
endmodule

/* design/price_level_order_book_top.sv */
// Channel   Ports                          Direction  Handshake
// input     start, busy, in_data           in         taken when start && !busy
// result    out_valid, out_data            out        one-cycle strobe, no backpressure
//
// An item passes S_CROSS, S_OWN (skipped by an add to a full side) and S_REPORT;
// in S_CROSS an add's crossing opposite levels leave the cell row head one per cycle.
// Reset is synchronous; rst_n low at a clock edge empties every cell.
// The receiver cannot stall: each result shows for one cycle only.
module price_level_order_book_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  plob_pkg::in_t  in_data,
  output logic           out_valid,
  output plob_pkg::out_t out_data
);
  import plob_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CROSS  = 4'b0010,
    S_OWN    = 4'b0100,
    S_REPORT = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  in_t        req_r;
  logic [1:0] status_r, status_nxt;
  logic       out_valid_r;
  out_t       out_r, out_nxt;
  ctrl_t      bctrl, actrl;
  side_stat_t bst, ast;
  logic       own_ask, opp_cross, own_found, own_full, is_add;
  side_stat_t own_st, opp_st;
  cmd_t       own_cmd, opp_cmd;
  logic [PW-1:0] bb, ba;

  assign is_add  = (req_r.opcode == OP_ADD);
  assign own_ask = (req_r.opcode == OP_TRADE) ? req_r.is_buy : !req_r.is_buy;
  assign own_st  = own_ask ? ast : bst;
  assign opp_st  = own_ask ? bst : ast;
  assign own_found = own_st.found;
  assign own_full  = own_st.full;
  assign opp_cross = opp_st.head.valid &&
                     (own_ask ? (opp_st.head.price >= req_r.price)
                              : (opp_st.head.price <= req_r.price));

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    own_cmd    = CMD_HOLD;
    opp_cmd    = CMD_HOLD;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CROSS;
      end
      S_CROSS: begin
        status_nxt = ST_OK;
        if (is_add && !own_found && own_full) begin
          status_nxt = ST_FULL;
          state_nxt  = S_REPORT;
        end else if (is_add && opp_cross) begin
          opp_cmd = CMD_POP;
        end else begin
          state_nxt = S_OWN;
        end
      end
      S_OWN: begin
        state_nxt = S_REPORT;
        case (req_r.opcode)
          OP_ADD: own_cmd = CMD_ADD;
          OP_TRADE, OP_CANCEL: begin
            if (own_found) own_cmd = CMD_REDUCE;
            else status_nxt = ST_NOTFOUND;
          end
          default: own_cmd = CMD_HOLD;
        endcase
      end
      S_REPORT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    bctrl.is_ask = 1'b0;
    actrl.is_ask = 1'b1;
    bctrl.price  = req_r.price;
    actrl.price  = req_r.price;
    bctrl.qty    = req_r.quantity;
    actrl.qty    = req_r.quantity;
    bctrl.qlevel = req_r.query_level;
    actrl.qlevel = req_r.query_level;
    bctrl.found  = bst.found;
    actrl.found  = ast.found;
    bctrl.remove = {{(QW-IQW){1'b0}}, req_r.quantity} >= bst.mqty;
    actrl.remove = {{(QW-IQW){1'b0}}, req_r.quantity} >= ast.mqty;
    bctrl.cmd    = own_ask ? opp_cmd : own_cmd;
    actrl.cmd    = own_ask ? own_cmd : opp_cmd;
  end

  plob_side u_bid (.clk(clk), .rst_n(rst_n), .ctrl(bctrl), .stat(bst));
  plob_side u_ask (.clk(clk), .rst_n(rst_n), .ctrl(actrl), .stat(ast));

  always_comb begin
    bb = bst.head.valid ? bst.head.price : '0;
    ba = ast.head.valid ? ast.head.price : '0;
    out_nxt.status      = status_r;
    out_nxt.best_bid    = bb;
    out_nxt.bid_present = bst.head.valid;
    out_nxt.best_ask    = ba;
    out_nxt.ask_present = ast.head.valid;
    out_nxt.spread      = (bst.head.valid && ast.head.valid) ? ba - bb : '0;
    out_nxt.level_bid_volume = bst.qvol;
    out_nxt.level_ask_volume = ast.qvol;
    out_nxt.volume_at_price  = bst.found ? bst.mqty : (ast.found ? ast.mqty : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= (state_r == S_REPORT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) req_r <= in_data;
    if (state_r == S_REPORT) out_r <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("transaction not taken");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
  a_no_cross: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bid_present && out_data.ask_present |->
    out_data.best_ask > out_data.best_bid) else $error("book crossed");
endmodule
